>>> rtl/rms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types, codes and constants of the range multilateration solver.
// ----------------------------------------------------------------------------
package rms_pkg;

	localparam int DATA_W    = 32;
	localparam int SLOT_W    = 3;
	localparam int GAIN_W    = 17;
	localparam int THR_W     = 16;
	localparam int ITER_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = 32;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd6554;
	localparam logic [THR_W-1:0]  THR_RESET  = 16'd1;
	localparam logic [ITER_W-1:0] ITER_RESET = 16'd4096;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd2;

	localparam logic [1:0] FN_LOCATION = 2'd0;
	localparam logic [1:0] FN_BIAS     = 2'd1;
	localparam logic [1:0] FN_RANGE    = 2'd2;
	localparam logic [1:0] FN_POSITION = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EV_NEXT,
		S_DIFF,
		S_SQX,
		S_SQY,
		S_SQA,
		S_SQRT,
		S_RES,
		S_DIVX,
		S_DIVY,
		S_ACC,
		S_STX,
		S_STXW,
		S_STY,
		S_STYW,
		S_DONE
	} state_t;

endpackage

>>> rtl/rms_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_isqrt
// Bit-serial integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rms_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rms_pkg::RAD_W-1:0]      radicand,
	output logic                           done,
	output logic [rms_pkg::ROOT_W-1:0]     root
);

	logic [rms_pkg::RAD_W-1:0] n_q, res_q, bit_q, trial;
	logic [4:0]                cnt_q;
	logic                      busy_q, done_q, ge;

	assign trial = res_q + bit_q;
	assign ge    = n_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			res_q <= '0;
			bit_q <= rms_pkg::RAD_W'(64'd1 << 62);
		end else if (busy_q) begin
			if (ge) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[rms_pkg::ROOT_W-1:0];

endmodule

>>> rtl/range_multilateration_solver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_multilateration_solver_core
// Beacon table with 2-D position solve by gradient descent on range residuals.
// ----------------------------------------------------------------------------
// Location, bias and range transactions write the beacon table when accepted. A
// position request with a fresh cached answer returns on the next cycle; otherwise a
// solve runs one shared multiplier, a bit-serial square root and a restoring
// divider over each valid beacon in turn, skipping empty slots, with one
// evaluation per descent iteration plus one initial, and a step of x and y per
// iteration. The input stalls for the whole solve.
module range_multilateration_solver_core #(
	parameter int NUM_BEACONS = 8,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic [rms_pkg::SLOT_W-1:0]          beacon_slot,
	input  logic signed [rms_pkg::DATA_W-1:0]   value,
	input  logic signed [rms_pkg::DATA_W-1:0]   second_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [rms_pkg::DATA_W-1:0]   pos_x,
	output logic signed [rms_pkg::DATA_W-1:0]   pos_y,
	output logic [rms_pkg::ITER_W-1:0]          iterations_used,
	output logic                                converged,
	input  logic                                cfg_wr_en,
	input  logic [rms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rms_pkg::GAIN_W-1:0]          cfg_wdata
);

	localparam int IW  = $clog2(NUM_BEACONS);
	localparam int CW  = $clog2(NUM_BEACONS + 1);
	localparam int QW  = FRAC_BITS + 1;
	localparam int DCW = $clog2(QW + 1);
	localparam int GW  = FRAC_BITS + $clog2(NUM_BEACONS) + 2;
	localparam logic signed [32:0] SMAX = 33'sd2147483647;
	localparam logic signed [32:0] SMIN = -33'sd2147483647;
	localparam logic signed [65:0] PMAX = 66'sd2147483647;
	localparam logic signed [65:0] PMIN = -66'sd2147483648;

	rms_pkg::state_t state_q, state_d;

	logic signed [31:0] bx_q [NUM_BEACONS];
	logic signed [31:0] by_q [NUM_BEACONS];
	logic signed [31:0] bias_q [NUM_BEACONS];
	logic signed [31:0] rng_q [NUM_BEACONS];
	logic [NUM_BEACONS-1:0] slot_valid_q;

	logic signed [31:0] px_q, py_q;
	logic               fresh_q;
	logic [16:0]        gain_q;
	logic [15:0]        thr_q, maxit_q;

	logic               out_valid_q, out_conv_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic [15:0]        out_iters_q;

	logic [CW-1:0]      bi_q;
	logic               phase_q;
	logic [15:0]        iters_q;
	logic               conv_q;
	logic [63:0]        err_q, prev_q;
	logic signed [GW-1:0] sx_q, sy_q;

	logic [30:0]        ax_q, ay_q;
	logic               dxneg_q, dyneg_q, inside_q;
	logic [63:0]        mul_q, sq_q;
	logic [31:0]        dist_q;
	logic [31:0]        rem_q;
	logic [QW-1:0]      q_q, dd_q, qx_q, qy_q;
	logic [DCW-1:0]     dcnt_q;

	logic               in_acc, slot_ok, bi_end, bi_ok, div_last, sq_done;
	logic [IW-1:0]      slot_idx, bi_idx;
	logic signed [32:0] rdiff, dxr, dyr, dxs, dys;
	logic signed [33:0] resid;
	logic [33:0]        resid_abs;
	logic [16:0]        cap, iters_nx;
	logic signed [64:0] ediff;
	logic [64:0]        ediff_abs;
	logic               stop_conv, stop_cap;
	logic [31:0]        mul_a, mul_b;
	logic [GW-1:0]      magx, magy;
	logic [63:0]        st;
	logic signed [65:0] pcur, pnew;
	logic               gneg;
	logic [32:0]        dtrial;
	logic               dge;
	logic [31:0]        sq_root;

	assign in_acc   = in_valid && !in_stall;
	assign slot_ok  = 32'(beacon_slot) < 32'(NUM_BEACONS);
	assign slot_idx = IW'(beacon_slot);
	assign bi_idx   = bi_q[IW-1:0];
	assign bi_end   = bi_q == CW'(NUM_BEACONS);
	assign bi_ok    = slot_valid_q[bi_idx];
	assign in_stall = (state_q != rms_pkg::S_IDLE) ||
		(func == rms_pkg::FN_POSITION && out_valid_q);

	assign rdiff = {value[31], value} - {bias_q[slot_idx][31], bias_q[slot_idx]};
	assign dxr   = {px_q[31], px_q} - {bx_q[bi_idx][31], bx_q[bi_idx]};
	assign dyr   = {py_q[31], py_q} - {by_q[bi_idx][31], by_q[bi_idx]};
	assign dxs   = dxr > SMAX ? SMAX : (dxr < SMIN ? SMIN : dxr);
	assign dys   = dyr > SMAX ? SMAX : (dyr < SMIN ? SMIN : dyr);

	assign resid     = $signed({2'b00, dist_q}) - {{2{rng_q[bi_idx][31]}}, rng_q[bi_idx]};
	assign resid_abs = resid[33] ? 34'(-resid) : 34'(resid);

	assign cap       = (maxit_q == 16'd0) ? 17'd1 : {1'b0, maxit_q};
	assign iters_nx  = {1'b0, iters_q} + 17'd1;
	assign ediff     = $signed({1'b0, prev_q}) - $signed({1'b0, err_q});
	assign ediff_abs = ediff[64] ? 65'(-ediff) : 65'(ediff);
	assign stop_conv = (iters_q != 16'd0) && (ediff_abs <= 65'(thr_q));
	assign stop_cap  = iters_nx >= cap;

	assign magx = sx_q[GW-1] ? GW'(-sx_q) : GW'(sx_q);
	assign magy = sy_q[GW-1] ? GW'(-sy_q) : GW'(sy_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			rms_pkg::S_SQX: begin
				mul_a = {1'b0, ax_q};
				mul_b = {1'b0, ax_q};
			end
			rms_pkg::S_SQY: begin
				mul_a = {1'b0, ay_q};
				mul_b = {1'b0, ay_q};
			end
			rms_pkg::S_STX: begin
				mul_a = 32'(gain_q);
				mul_b = 32'(magx);
			end
			rms_pkg::S_STY: begin
				mul_a = 32'(gain_q);
				mul_b = 32'(magy);
			end
			default: ;
		endcase
	end

	assign st   = mul_q >> FRAC_BITS;
	assign gneg = (state_q == rms_pkg::S_STXW) ? sx_q[GW-1] : sy_q[GW-1];
	assign pcur = (state_q == rms_pkg::S_STXW) ? 66'(px_q) : 66'(py_q);
	assign pnew = gneg ? pcur + $signed({2'b00, st}) : pcur - $signed({2'b00, st});

	assign dtrial   = {rem_q, dd_q[QW-1]};
	assign dge      = dtrial >= {1'b0, dist_q};
	assign div_last = dcnt_q == DCW'(QW - 1);

	rms_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == rms_pkg::S_SQA),
		.radicand (sq_q + mul_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rms_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rms_pkg::S_IDLE:
				if (in_acc && func == rms_pkg::FN_POSITION && !fresh_q)
					state_d = rms_pkg::S_EV_NEXT;
			rms_pkg::S_EV_NEXT:
				if (bi_end) begin
					if (!phase_q || !(stop_conv || stop_cap))
						state_d = rms_pkg::S_STX;
					else
						state_d = rms_pkg::S_DONE;
				end else if (bi_ok) begin
					state_d = rms_pkg::S_DIFF;
				end
			rms_pkg::S_DIFF: state_d = rms_pkg::S_SQX;
			rms_pkg::S_SQX:  state_d = rms_pkg::S_SQY;
			rms_pkg::S_SQY:  state_d = rms_pkg::S_SQA;
			rms_pkg::S_SQA:  state_d = rms_pkg::S_SQRT;
			rms_pkg::S_SQRT:
				if (sq_done)
					state_d = rms_pkg::S_RES;
			rms_pkg::S_RES:
				state_d = (dist_q == 32'd0) ? rms_pkg::S_EV_NEXT : rms_pkg::S_DIVX;
			rms_pkg::S_DIVX:
				if (div_last)
					state_d = rms_pkg::S_DIVY;
			rms_pkg::S_DIVY:
				if (div_last)
					state_d = rms_pkg::S_ACC;
			rms_pkg::S_ACC:  state_d = rms_pkg::S_EV_NEXT;
			rms_pkg::S_STX:  state_d = rms_pkg::S_STXW;
			rms_pkg::S_STXW: state_d = rms_pkg::S_STY;
			rms_pkg::S_STY:  state_d = rms_pkg::S_STYW;
			rms_pkg::S_STYW: state_d = rms_pkg::S_EV_NEXT;
			rms_pkg::S_DONE: state_d = rms_pkg::S_IDLE;
			default:         state_d = rms_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BEACONS; i++) begin
				bx_q[i]   <= '0;
				by_q[i]   <= '0;
				bias_q[i] <= '0;
				rng_q[i]  <= '0;
			end
			slot_valid_q <= '0;
			px_q         <= '0;
			py_q         <= 32'(64'd2 << FRAC_BITS);
			fresh_q      <= 1'b0;
			gain_q       <= rms_pkg::GAIN_RESET;
			thr_q        <= rms_pkg::THR_RESET;
			maxit_q      <= rms_pkg::ITER_RESET;
			out_valid_q  <= 1'b0;
			bi_q         <= '0;
			phase_q      <= 1'b0;
			iters_q      <= '0;
			conv_q       <= 1'b0;
			dcnt_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					rms_pkg::CFG_STEP_GAIN:      gain_q  <= cfg_wdata;
					rms_pkg::CFG_STOP_THRESHOLD: thr_q   <= cfg_wdata[15:0];
					rms_pkg::CFG_MAX_ITERATIONS: maxit_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			if (in_acc && slot_ok) begin
				case (func)
					rms_pkg::FN_LOCATION: begin
						bx_q[slot_idx]         <= value;
						by_q[slot_idx]         <= second_value;
						slot_valid_q[slot_idx] <= 1'b1;
					end
					rms_pkg::FN_BIAS: bias_q[slot_idx] <= value;
					rms_pkg::FN_RANGE: begin
						rng_q[slot_idx] <= (rdiff > SMAX) ? 32'sh7fffffff :
							(rdiff < -33'sd2147483648) ? 32'sh80000000 : rdiff[31:0];
						fresh_q <= 1'b0;
					end
					default: ;
				endcase
			end

			unique case (state_q)
				rms_pkg::S_IDLE:
					if (in_acc && func == rms_pkg::FN_POSITION) begin
						if (fresh_q) begin
							out_valid_q <= 1'b1;
						end else begin
							bi_q    <= '0;
							phase_q <= 1'b0;
							iters_q <= '0;
							conv_q  <= 1'b0;
						end
					end
				rms_pkg::S_EV_NEXT:
					if (bi_end) begin
						if (phase_q) begin
							iters_q <= iters_nx[15:0];
							conv_q  <= stop_conv;
						end
					end else if (!bi_ok) begin
						bi_q <= bi_q + CW'(1);
					end
				rms_pkg::S_RES: begin
					dcnt_q <= '0;
					if (dist_q == 32'd0)
						bi_q <= bi_q + CW'(1);
				end
				rms_pkg::S_DIVX, rms_pkg::S_DIVY:
					dcnt_q <= div_last ? '0 : dcnt_q + DCW'(1);
				rms_pkg::S_ACC:
					bi_q <= bi_q + CW'(1);
				rms_pkg::S_STXW:
					px_q <= (pnew > PMAX) ? 32'sh7fffffff :
						(pnew < PMIN) ? 32'sh80000000 : pnew[31:0];
				rms_pkg::S_STYW: begin
					py_q    <= (pnew > PMAX) ? 32'sh7fffffff :
						(pnew < PMIN) ? 32'sh80000000 : pnew[31:0];
					bi_q    <= '0;
					phase_q <= 1'b1;
				end
				rms_pkg::S_DONE: begin
					fresh_q     <= 1'b1;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		unique case (state_q)
			rms_pkg::S_IDLE: begin
				if (in_acc && func == rms_pkg::FN_POSITION) begin
					out_x_q     <= px_q;
					out_y_q     <= py_q;
					out_iters_q <= '0;
					out_conv_q  <= 1'b1;
				end
				err_q       <= '0;
				prev_q      <= '0;
				sx_q        <= '0;
				sy_q        <= '0;
			end
			rms_pkg::S_EV_NEXT:
				if (bi_end && phase_q)
					prev_q <= err_q;
			rms_pkg::S_DIFF: begin
				ax_q    <= dxs[32] ? 31'(-dxs) : 31'(dxs);
				ay_q    <= dys[32] ? 31'(-dys) : 31'(dys);
				dxneg_q <= dxs[32];
				dyneg_q <= dys[32];
			end
			rms_pkg::S_SQY:
				sq_q <= mul_q;
			rms_pkg::S_SQRT:
				dist_q <= sq_root;
			rms_pkg::S_RES: begin
				err_q    <= err_q + 64'(resid_abs);
				inside_q <= resid[33];
				rem_q    <= {2'b00, ax_q[30:1]};
				dd_q     <= {ax_q[0], {FRAC_BITS{1'b0}}};
				q_q      <= '0;
			end
			rms_pkg::S_DIVX, rms_pkg::S_DIVY: begin
				if (div_last) begin
					if (state_q == rms_pkg::S_DIVX) begin
						qx_q  <= {q_q[QW-2:0], dge};
						rem_q <= {2'b00, ay_q[30:1]};
						dd_q  <= {ay_q[0], {FRAC_BITS{1'b0}}};
						q_q   <= '0;
					end else begin
						qy_q <= {q_q[QW-2:0], dge};
					end
				end else begin
					rem_q <= dge ? 32'(dtrial - {1'b0, dist_q}) : dtrial[31:0];
					q_q   <= {q_q[QW-2:0], dge};
					dd_q  <= dd_q << 1;
				end
			end
			rms_pkg::S_ACC: begin
				sx_q <= (dxneg_q ^ inside_q) ? sx_q - $signed(GW'(qx_q)) :
					sx_q + $signed(GW'(qx_q));
				sy_q <= (dyneg_q ^ inside_q) ? sy_q - $signed(GW'(qy_q)) :
					sy_q + $signed(GW'(qy_q));
			end
			rms_pkg::S_STYW: begin
				err_q <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
			end
			rms_pkg::S_DONE: begin
				out_x_q     <= px_q;
				out_y_q     <= py_q;
				out_iters_q <= iters_q;
				out_conv_q  <= conv_q;
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign pos_x           = out_x_q;
	assign pos_y           = out_y_q;
	assign iterations_used = out_iters_q;
	assign converged       = out_conv_q;

	a_fresh_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> fresh_q)
		else $error("result raised without a fresh position");
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == rms_pkg::S_IDLE)
		else $error("solve running while a result waits");
	a_root_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == rms_pkg::S_SQRT)
		else $error("square root finished outside its wait state");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rms_pkg::S_DIVX || state_q == rms_pkg::S_DIVY) |-> dist_q != 32'd0)
		else $error("divide by zero distance");

endmodule

>>> bench/tb_range_multilateration_solver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_multilateration_solver_core
// Self-checking bench for the beacon table and gradient descent position solve.
// ----------------------------------------------------------------------------
// A scoreboard class carries its own copy of the beacon table, the cached
// position and the three registers. It works out the answer of every accepted
// position request and compares each returned position, field by field, in
// order. Stimulus runs a directed opening (register extremes, empty table,
// saturated ranges, cached answers) and then random measurement epochs under
// several register settings. Both channels idle in random bursts, except
// in the last stretch of the run.
// ----------------------------------------------------------------------------
module tb_range_multilateration_solver_core;

	typedef struct {
		logic signed [rms_pkg::DATA_W-1:0] px;
		logic signed [rms_pkg::DATA_W-1:0] py;
		logic [rms_pkg::ITER_W-1:0]        iters;
		logic                              conv;
	} position_t;

	class position_scoreboard;
		longint    bcn_x[8];
		longint    bcn_y[8];
		longint    bias[8];
		longint    rng[8];
		bit        in_table[8];
		longint    cur_x;
		longint    cur_y;
		bit        fresh;
		longint    gain;
		longint    thr;
		longint    max_it;
		position_t pending_pos[$];
		int        errors;
		int        solves;
		int        cached;

		function new();
			for (int i = 0; i < 8; i++) begin
				bcn_x[i] = 0; bcn_y[i] = 0; bias[i] = 0; rng[i] = 0; in_table[i] = 0;
			end
			cur_x = 0;
			cur_y = 2 <<< 16;
			fresh = 0;
			gain = rms_pkg::GAIN_RESET;
			thr = rms_pkg::THR_RESET;
			max_it = rms_pkg::ITER_RESET;
			errors = 0;
			solves = 0;
			cached = 0;
		endfunction

		function void set_reg(logic [rms_pkg::CFG_IDX_W-1:0] idx,
				logic [rms_pkg::GAIN_W-1:0] data);
			case (idx)
				rms_pkg::CFG_STEP_GAIN:      gain = data;
				rms_pkg::CFG_STOP_THRESHOLD: thr = data[rms_pkg::THR_W-1:0];
				rms_pkg::CFG_MAX_ITERATIONS: max_it = data[rms_pkg::ITER_W-1:0];
				default: ;
			endcase
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint sat_diff(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483647) return -64'sd2147483647;
			return v;
		endfunction

		function logic [63:0] isqrt(logic [63:0] n);
			logic [63:0] res;
			logic [63:0] bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n = n - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		function longint residual_sum(longint px, longint py, output longint gx,
				output longint gy);
			longint err, dx, dy, span, res, qx, qy;
			logic [63:0] ax, ay;
			err = 0; gx = 0; gy = 0;
			for (int i = 0; i < 8; i++) begin
				if (in_table[i]) begin
					dx = sat_diff(px - bcn_x[i]);
					dy = sat_diff(py - bcn_y[i]);
					ax = dx < 0 ? -dx : dx;
					ay = dy < 0 ? -dy : dy;
					span = isqrt(ax * ax + ay * ay);
					res = span - rng[i];
					err += res < 0 ? -res : res;
					if (span != 0) begin
						qx = longint'((ax << 16) / span);
						qy = longint'((ay << 16) / span);
						if (dx < 0) qx = -qx;
						if (dy < 0) qy = -qy;
						if (span < rng[i]) begin
							qx = -qx; qy = -qy;
						end
						gx += qx;
						gy += qy;
					end
				end
			end
			return err;
		endfunction

		function longint descend(longint p, longint g);
			longint mag, st;
			mag = g < 0 ? -g : g;
			st = (gain * mag) >>> 16;
			return sat32(p - (g < 0 ? -st : st));
		endfunction

		function void note_item(logic [1:0] fn, logic [rms_pkg::SLOT_W-1:0] slot,
				logic signed [rms_pkg::DATA_W-1:0] v1,
				logic signed [rms_pkg::DATA_W-1:0] v2);
			position_t r;
			longint px, py, prev, cur, gx, gy, dgx, dgy, diff, cap, n;
			bit conv;
			case (fn)
				rms_pkg::FN_LOCATION: begin
					bcn_x[slot] = v1; bcn_y[slot] = v2; in_table[slot] = 1;
				end
				rms_pkg::FN_BIAS: bias[slot] = v1;
				rms_pkg::FN_RANGE: begin
					rng[slot] = sat32(longint'(v1) - bias[slot]);
					fresh = 0;
				end
				default: begin
					n = 0;
					conv = 1;
					if (!fresh) begin
						solves++;
						px = cur_x; py = cur_y; prev = 0;
						cap = max_it == 0 ? 1 : max_it;
						conv = 0;
						while (n < cap) begin
							void'(residual_sum(px, py, gx, gy));
							px = descend(px, gx);
							py = descend(py, gy);
							cur = residual_sum(px, py, dgx, dgy);
							n++;
							diff = prev - cur;
							if (diff < 0) diff = -diff;
							if (n > 1 && diff <= thr) begin
								conv = 1;
								break;
							end
							prev = cur;
						end
						cur_x = px; cur_y = py; fresh = 1;
					end else begin
						cached++;
					end
					r.px = cur_x[31:0];
					r.py = cur_y[31:0];
					r.iters = n[15:0];
					r.conv = conv;
					pending_pos = {pending_pos, r};
				end
			endcase
		endfunction

		function void check_result(logic signed [rms_pkg::DATA_W-1:0] px,
				logic signed [rms_pkg::DATA_W-1:0] py, logic [rms_pkg::ITER_W-1:0] it,
				logic cv);
			position_t e;
			if (pending_pos.size() == 0) begin
				$error("unexpected position result x=%0d y=%0d", px, py);
				errors++;
				return;
			end
			e = pending_pos.pop_front();
			if (px !== e.px) begin
				$error("pos_x expected %0d actual %0d", e.px, px); errors++;
			end
			if (py !== e.py) begin
				$error("pos_y expected %0d actual %0d", e.py, py); errors++;
			end
			if (it !== e.iters) begin
				$error("iterations_used expected %0d actual %0d", e.iters, it); errors++;
			end
			if (cv !== e.conv) begin
				$error("converged expected %0d actual %0d", e.conv, cv); errors++;
			end
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic [1:0]                         func;
	logic [rms_pkg::SLOT_W-1:0]         beacon_slot;
	logic signed [rms_pkg::DATA_W-1:0]  value;
	logic signed [rms_pkg::DATA_W-1:0]  second_value;
	logic                               out_valid;
	logic                               out_stall;
	logic signed [rms_pkg::DATA_W-1:0]  pos_x;
	logic signed [rms_pkg::DATA_W-1:0]  pos_y;
	logic [rms_pkg::ITER_W-1:0]         iterations_used;
	logic                               converged;
	logic                               cfg_wr_en;
	logic [rms_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [rms_pkg::GAIN_W-1:0]         cfg_wdata;

	position_scoreboard sb = new();
	bit quiet = 0;
	int items_sent = 0;
	int reg_phases = 0;

	range_multilateration_solver_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .beacon_slot(beacon_slot), .value(value), .second_value(second_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .iterations_used(iterations_used),
		.converged(converged),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	initial begin
		#50ms;
		$display("tb_range_multilateration_solver_core NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(pos_x, pos_y, iterations_used, converged);
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet || $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_stall <= 1'($urandom_range(0, 1));
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic send_item(logic [1:0] fn, logic [rms_pkg::SLOT_W-1:0] slot,
			logic signed [rms_pkg::DATA_W-1:0] v1, logic signed [rms_pkg::DATA_W-1:0] v2);
		in_valid <= 1'b1;
		func <= fn;
		beacon_slot <= slot;
		value <= v1;
		second_value <= v2;
		do @(posedge clk); while (in_stall);
		sb.note_item(fn, slot, v1, v2);
		items_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_pos.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [rms_pkg::CFG_IDX_W-1:0] idx,
			logic [rms_pkg::GAIN_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic set_regs(logic [rms_pkg::GAIN_W-1:0] g, logic [rms_pkg::GAIN_W-1:0] t,
			logic [rms_pkg::GAIN_W-1:0] m);
		drain();
		write_reg(rms_pkg::CFG_STEP_GAIN, g);
		write_reg(rms_pkg::CFG_STOP_THRESHOLD, t);
		write_reg(rms_pkg::CFG_MAX_ITERATIONS, m);
		reg_phases++;
	endtask

	function automatic logic signed [rms_pkg::DATA_W-1:0] near_coord();
		if ($urandom_range(0, 11) == 0) return $urandom;
		return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
	endfunction

	function automatic logic signed [rms_pkg::DATA_W-1:0] near_range();
		if ($urandom_range(0, 11) == 0) return $urandom;
		return $urandom_range(0, 30 << 16);
	endfunction

	function automatic logic [rms_pkg::SLOT_W-1:0] any_slot();
		return rms_pkg::SLOT_W'($urandom_range(0, 7));
	endfunction

	task automatic measurement_epoch();
		int k;
		k = $urandom_range(1, 5);
		if ($urandom_range(0, 2) == 0)
			send_item(rms_pkg::FN_LOCATION, any_slot(), near_coord(), near_coord());
		if ($urandom_range(0, 3) == 0)
			send_item(rms_pkg::FN_BIAS, any_slot(),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2 << 16), $urandom);
		for (int i = 0; i < k; i++)
			send_item(rms_pkg::FN_RANGE, any_slot(), near_range(), $urandom);
		send_item(rms_pkg::FN_POSITION, any_slot(), $urandom, $urandom);
		if ($urandom_range(0, 4) == 0)
			send_item(rms_pkg::FN_POSITION, any_slot(), $urandom, $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = rms_pkg::FN_LOCATION;
		beacon_slot = '0;
		value = '0;
		second_value = '0;
		cfg_wr_en = 1'b0;
		cfg_index = rms_pkg::CFG_STEP_GAIN;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table under reset registers, then register extremes
		send_item(rms_pkg::FN_POSITION, 3'd0, '0, '0);
		send_item(rms_pkg::FN_POSITION, 3'd7, '1, '1);
		send_item(rms_pkg::FN_RANGE, 3'd2, 32'sd65536, '0);
		send_item(rms_pkg::FN_POSITION, 3'd0, '0, '0);
		set_regs(17'h1FFFF, 17'd0, 17'd65535);
		send_item(rms_pkg::FN_RANGE, 3'd1, 32'sd1, '0);
		send_item(rms_pkg::FN_POSITION, 3'd1, '0, '0);
		set_regs(17'd0, 17'd65535, 17'd0);
		send_item(rms_pkg::FN_RANGE, 3'd1, 32'sd1, '0);
		send_item(rms_pkg::FN_POSITION, 3'd1, '0, '0);

		// saturated ranges, far beacon, cached answers
		set_regs(17'd65536, 17'd1, 17'd8);
		send_item(rms_pkg::FN_LOCATION, 3'd0, 32'sd0, 32'sd0);
		send_item(rms_pkg::FN_LOCATION, 3'd1, 32'sd10 <<< 16, 32'sd0);
		send_item(rms_pkg::FN_LOCATION, 3'd7, 32'sh7FFFFFFF, 32'sh80000000);
		send_item(rms_pkg::FN_BIAS, 3'd7, 32'sh7FFFFFFF, '0);
		send_item(rms_pkg::FN_RANGE, 3'd7, 32'sh80000000, '0);
		send_item(rms_pkg::FN_BIAS, 3'd1, 32'sh80000000, '0);
		send_item(rms_pkg::FN_RANGE, 3'd1, 32'sh7FFFFFFF, '0);
		send_item(rms_pkg::FN_POSITION, 3'd0, '0, '0);
		send_item(rms_pkg::FN_LOCATION, 3'd7, 32'sd0, 32'sd10 <<< 16);
		send_item(rms_pkg::FN_BIAS, 3'd1, 32'sd0, '0);
		send_item(rms_pkg::FN_BIAS, 3'd7, 32'sd0, '0);
		send_item(rms_pkg::FN_POSITION, 3'd0, '0, '0);
		send_item(rms_pkg::FN_RANGE, 3'd0, 32'sd7 <<< 16, '0);
		send_item(rms_pkg::FN_RANGE, 3'd1, 32'sd7 <<< 16, '0);
		send_item(rms_pkg::FN_RANGE, 3'd7, 32'sd7 <<< 16, '0);
		send_item(rms_pkg::FN_POSITION, 3'd0, '0, '0);
		send_item(rms_pkg::FN_POSITION, 3'd0, '0, '0);

		for (int ph = 0; ph < 4; ph++) begin
			set_regs($urandom_range(0, 5) == 0 ? 17'($urandom_range(0, 131071))
					: 17'($urandom_range(0, 65536)),
				17'($urandom_range(0, 65535)), 17'($urandom_range(1, 16)));
			while (items_sent < 20 + 25 * (ph + 1)) begin
				if ($urandom_range(0, 4) == 0)
					send_item(2'($urandom), rms_pkg::SLOT_W'($urandom), $urandom, $urandom);
				else
					measurement_epoch();
				if (ph == 1 && items_sent > 55 && items_sent < 62)
					drain();
			end
		end
		quiet = 1;
		while (items_sent < 140) measurement_epoch();

		drain();
		repeat (50) @(posedge clk);
		$display("run: %0d transactions, %0d solves, %0d cached answers, %0d register settings",
			items_sent, sb.solves, sb.cached, reg_phases);
		if (sb.errors == 0 && sb.pending_pos.size() == 0)
			$display("tb_range_multilateration_solver_core OK");
		else
			$display("tb_range_multilateration_solver_core NOT OK");
		$finish;
	end

endmodule

>>> files.f
rtl/rms_pkg.sv
rtl/rms_isqrt.sv
rtl/range_multilateration_solver_core.sv
bench/tb_range_multilateration_solver_core.sv
